### rtl/core/clock_alarm_command_frames_assert.svh
// Assertion macros used by the clock and alarm RTL.
`ifndef CLOCK_ALARM_COMMAND_FRAMES_ASSERT_SVH
`define CLOCK_ALARM_COMMAND_FRAMES_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define CACF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CACF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define CACF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CACF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/cacf_pkg.sv
// Constants, codes and small helper functions for the clock and alarm block.
package cacf_pkg;

  localparam int MAX_FRAME_DEF = 128;
  localparam int HEAD_DEPTH    = 10;

  // Item actions.
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  // Clock modes.
  localparam logic [1:0] MODE_UNSET = 2'd0;
  localparam logic [1:0] MODE_AM    = 2'd1;
  localparam logic [1:0] MODE_PM    = 2'd2;

  // Frame status codes.
  localparam logic [1:0] FS_NONE   = 2'd0;
  localparam logic [1:0] FS_ACCEPT = 2'd1;
  localparam logic [1:0] FS_REJECT = 2'd2;

  // Command codes.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_AM    = 3'd2;
  localparam logic [2:0] CMD_PM    = 3'd3;
  localparam logic [2:0] CMD_ALARM = 3'd4;

  // LED colors.
  localparam logic [1:0] LED_OFF   = 2'd0;
  localparam logic [1:0] LED_BLUE  = 2'd1;
  localparam logic [1:0] LED_GREEN = 2'd2;
  localparam logic [1:0] LED_RED   = 2'd3;

  // Characters.
  localparam logic [7:0] CH_0   = 8'd48;
  localparam logic [7:0] CH_9   = 8'd57;
  localparam logic [7:0] CH_A   = 8'd65;
  localparam logic [7:0] CH_Z   = 8'd90;
  localparam logic [7:0] CH_LBR = 8'd91;
  localparam logic [7:0] CH_RBR = 8'd93;
  localparam logic [7:0] CH_S   = 8'd83;
  localparam logic [7:0] CH_T   = 8'd84;
  localparam logic [7:0] CH_H   = 8'd72;
  localparam logic [7:0] CH_G   = 8'd71;
  localparam logic [7:0] CH_P   = 8'd80;
  localparam logic [7:0] CH_M   = 8'd77;

  localparam logic [6:0] MAX_MS      = 7'd59;
  localparam logic [6:0] MAX_HOUR_AM = 7'd12;
  localparam logic [6:0] MAX_HOUR_PM = 7'd23;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic char_allowed(input logic [7:0] c);
    return is_digit(c) || ((c >= CH_A) && (c <= CH_Z)) || (c == CH_LBR) || (c == CH_RBR);
  endfunction

  // Two decimal digits to a binary value up to 99.
  function automatic logic [6:0] two_digits(input logic [7:0] hi, input logic [7:0] lo);
    return ({3'd0, hi[3:0]} * 7'd10) + {3'd0, lo[3:0]};
  endfunction

  function automatic logic time_valid(input logic [1:0] mode, input logic [6:0] h,
                                      input logic [6:0] m, input logic [6:0] s);
    logic ok;
    ok = (m <= MAX_MS) && (s <= MAX_MS);
    if (mode == MODE_AM) begin
      ok = ok && (h >= 7'd1) && (h <= MAX_HOUR_AM);
    end else begin
      ok = ok && (h <= MAX_HOUR_PM);
    end
    return ok;
  endfunction

  // Phase counts 0, 1, 2 and around.
  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p >= 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  // The color shown is the one before the phase, that is the last one stepped to.
  function automatic logic [1:0] phase_color(input logic [1:0] p);
    logic [1:0] c;
    case (p)
      2'd0:    c = LED_RED;
      2'd1:    c = LED_BLUE;
      2'd2:    c = LED_GREEN;
      default: c = LED_OFF;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/cacf_if.sv
// Valid/ready channel interfaces for command items and clock status results.
interface cacf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output action, output rx_byte, output frame_end,
                  input ready);
  modport sink (input valid, input action, input rx_byte, input frame_end,
                output ready);
endinterface

interface cacf_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [1:0] clock_mode;
  logic       clock_running;
  logic       alarm_armed;
  logic       alarm_ringing;
  logic [1:0] led_color;
  logic [1:0] frame_status;
  logic [2:0] command_seen;

  modport source (output valid, output hour, output minute, output second,
                  output clock_mode, output clock_running, output alarm_armed,
                  output alarm_ringing, output led_color, output frame_status,
                  output command_seen, input ready);
  modport sink (input valid, input hour, input minute, input second,
                input clock_mode, input clock_running, input alarm_armed,
                input alarm_ringing, input led_color, input frame_status,
                input command_seen, output ready);
endinterface

### rtl/core/clock_alarm_command_frames.sv
// Time-of-day clock with one alarm, driven by command frame bytes and second ticks.
// Throughput: one item per cycle while the result side keeps up; each accepted beat yields
// exactly one result beat. An item passes through the input register, then the result register,
// which holds its result beat until it is taken.
// Reset (rst, synchronous, active high) clears the time, alarm, mode, flags and frame buffer.
// No clearing pass is needed: items are accepted from the first cycle after reset.
`include "clock_alarm_command_frames_assert.svh"

module clock_alarm_command_frames #(
  parameter int MAX_FRAME = cacf_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cacf_in_if.sink    item,
  cacf_out_if.source result
);

  // The frame length counter must hold MAX_FRAME itself, where it saturates.
  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  // ---------------------------------------------------------------------------
  // Pipeline control. The input register takes a beat whenever it is empty or
  // is handing its item on; it hands on whenever the result register is empty
  // or its beat is being taken. So a beat is accepted every cycle as long as
  // the result side keeps up. A waiting result stalls the input only once the
  // input register also holds an item behind it, so two beats fill the block.
  // ---------------------------------------------------------------------------
  logic       in_valid;
  logic [1:0] in_action;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       advance;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_action <= item.action;
      in_byte   <= item.rx_byte;
      in_last   <= item.frame_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state.
  // ---------------------------------------------------------------------------
  logic [7:0]       frame_head [cacf_pkg::HEAD_DEPTH];
  logic [CNT_W-1:0] frame_count;
  logic             frame_chars_ok;
  logic [4:0]       clk_hour;
  logic [5:0]       clk_min;
  logic [5:0]       clk_sec;
  logic [4:0]       alm_hour;
  logic [5:0]       alm_min;
  logic [5:0]       alm_sec;
  logic [1:0]       mode_reg;
  logic             start_seen;
  logic             run_flag;
  logic             armed_flag;
  logic             ringing_flag;
  logic [1:0]       led_phase;

  // ---------------------------------------------------------------------------
  // Byte capture: the frame buffer, length and character check after this
  // item's byte lands, before any end-of-frame clearing. Only the first ten
  // bytes are kept; later ones count toward the length limit alone.
  // ---------------------------------------------------------------------------
  logic [7:0]       head_wr [cacf_pkg::HEAD_DEPTH];
  logic [CNT_W-1:0] count_wr;
  logic             ok_wr;
  logic             frame_full;

  assign frame_full = (frame_count >= CNT_W'(MAX_FRAME));

  always_comb begin
    head_wr  = frame_head;
    count_wr = frame_count;
    ok_wr    = frame_chars_ok;
    if (frame_full) begin
      ok_wr = 1'b0;
    end else begin
      for (int i = 0; i < cacf_pkg::HEAD_DEPTH; i++) begin
        if (frame_count == CNT_W'(i)) begin
          head_wr[i] = in_byte;
        end
      end
      count_wr = frame_count + CNT_W'(1);
      if (!cacf_pkg::char_allowed(in_byte)) begin
        ok_wr = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Frame decode from the captured head. Bytes never reached read as zero.
  // ---------------------------------------------------------------------------
  logic       frame_good;
  logic       digits_ok;
  logic [6:0] dec_h;
  logic [6:0] dec_m;
  logic [6:0] dec_s;
  logic       is_start;
  logic       is_alarm;
  logic       is_set;
  logic       set_am;
  logic [1:0] set_mode;
  logic       mode_known;

  assign frame_good = ok_wr && (head_wr[0] == cacf_pkg::CH_LBR) &&
                      ((head_wr[6] == cacf_pkg::CH_RBR) || (head_wr[9] == cacf_pkg::CH_RBR));

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 3; i <= 8; i++) begin
      if (!cacf_pkg::is_digit(head_wr[i])) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign dec_h = cacf_pkg::two_digits(head_wr[3], head_wr[4]);
  assign dec_m = cacf_pkg::two_digits(head_wr[5], head_wr[6]);
  assign dec_s = cacf_pkg::two_digits(head_wr[7], head_wr[8]);

  assign is_start   = (head_wr[1] == cacf_pkg::CH_S) && (head_wr[2] == cacf_pkg::CH_T);
  assign is_alarm   = (head_wr[1] == cacf_pkg::CH_H) && (head_wr[2] == cacf_pkg::CH_G);
  assign set_am     = (head_wr[1] == cacf_pkg::CH_A);
  assign is_set     = (set_am || (head_wr[1] == cacf_pkg::CH_P)) &&
                      (head_wr[2] == cacf_pkg::CH_M);
  assign set_mode   = set_am ? cacf_pkg::MODE_AM : cacf_pkg::MODE_PM;
  assign mode_known = (mode_reg == cacf_pkg::MODE_AM) || (mode_reg == cacf_pkg::MODE_PM);

  // ---------------------------------------------------------------------------
  // Next state and result for the item in the input register.
  // ---------------------------------------------------------------------------
  logic [7:0]       head_next [cacf_pkg::HEAD_DEPTH];
  logic [CNT_W-1:0] count_next;
  logic             ok_next;
  logic [4:0]       hour_next;
  logic [5:0]       min_next;
  logic [5:0]       sec_next;
  logic [4:0]       alm_hour_next;
  logic [5:0]       alm_min_next;
  logic [5:0]       alm_sec_next;
  logic [1:0]       mode_next;
  logic             start_next;
  logic             run_next;
  logic             armed_next;
  logic             ringing_next;
  logic [1:0]       phase_next;
  logic [1:0]       status_next;
  logic [2:0]       cmd_next;
  logic             check_alarm;

  always_comb begin
    head_next     = frame_head;
    count_next    = frame_count;
    ok_next       = frame_chars_ok;
    hour_next     = clk_hour;
    min_next      = clk_min;
    sec_next      = clk_sec;
    alm_hour_next = alm_hour;
    alm_min_next  = alm_min;
    alm_sec_next  = alm_sec;
    mode_next     = mode_reg;
    start_next    = start_seen;
    run_next      = run_flag;
    armed_next    = armed_flag;
    ringing_next  = ringing_flag;
    phase_next    = led_phase;
    status_next   = cacf_pkg::FS_NONE;
    cmd_next      = cacf_pkg::CMD_NONE;
    check_alarm   = 1'b0;

    case (in_action)
      cacf_pkg::ACT_BYTE: begin
        head_next  = head_wr;
        count_next = count_wr;
        ok_next    = ok_wr;
        if (in_last) begin
          if (frame_good) begin
            status_next = cacf_pkg::FS_ACCEPT;
            check_alarm = 1'b1;
            if (is_start) begin
              start_next = 1'b1;
              cmd_next   = cacf_pkg::CMD_START;
            end else if (digits_ok) begin
              if (is_alarm) begin
                // Arming needs a known mode and a time valid in that mode.
                if (mode_known && cacf_pkg::time_valid(mode_reg, dec_h, dec_m, dec_s)) begin
                  armed_next    = 1'b1;
                  alm_hour_next = dec_h[4:0];
                  alm_min_next  = dec_m[5:0];
                  alm_sec_next  = dec_s[5:0];
                  cmd_next      = cacf_pkg::CMD_ALARM;
                end
              end else if (is_set) begin
                // The mode changes even when the time is out of range.
                mode_next = set_mode;
                if (cacf_pkg::time_valid(set_mode, dec_h, dec_m, dec_s)) begin
                  hour_next = dec_h[4:0];
                  min_next  = dec_m[5:0];
                  sec_next  = dec_s[5:0];
                end
                cmd_next = set_am ? cacf_pkg::CMD_AM : cacf_pkg::CMD_PM;
              end
            end
            if (start_next && ((mode_next == cacf_pkg::MODE_AM) ||
                               (mode_next == cacf_pkg::MODE_PM))) begin
              run_next = 1'b1;
            end
          end else begin
            status_next = cacf_pkg::FS_REJECT;
          end
          for (int i = 0; i < cacf_pkg::HEAD_DEPTH; i++) begin
            head_next[i] = 8'd0;
          end
          count_next = '0;
          ok_next    = 1'b1;
        end
      end
      cacf_pkg::ACT_TICK: begin
        if (ringing_flag) begin
          phase_next = cacf_pkg::inc3(led_phase);
        end
        if (run_flag) begin
          check_alarm = 1'b1;
          if (clk_sec >= 6'd59) begin
            sec_next = 6'd0;
            if (clk_min >= 6'd59) begin
              min_next = 6'd0;
              if (mode_reg == cacf_pkg::MODE_AM) begin
                hour_next = (clk_hour >= 5'd12) ? 5'd1 : clk_hour + 5'd1;
              end else begin
                hour_next = (clk_hour >= 5'd23) ? 5'd0 : clk_hour + 5'd1;
              end
            end else begin
              min_next = clk_min + 6'd1;
            end
          end else begin
            sec_next = clk_sec + 6'd1;
          end
        end
      end
      cacf_pkg::ACT_STOP: begin
        ringing_next = 1'b0;
      end
      default: begin
      end
    endcase

    // The alarm fires on a match, but a match while already ringing is ignored.
    if (check_alarm && armed_next && !ringing_next && (hour_next == alm_hour_next) &&
        (min_next == alm_min_next) && (sec_next == alm_sec_next)) begin
      ringing_next = 1'b1;
      phase_next   = cacf_pkg::inc3(phase_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cacf_pkg::HEAD_DEPTH; i++) begin
        frame_head[i] <= 8'd0;
      end
      frame_count    <= '0;
      frame_chars_ok <= 1'b1;
      clk_hour       <= 5'd0;
      clk_min        <= 6'd0;
      clk_sec        <= 6'd0;
      alm_hour       <= 5'd0;
      alm_min        <= 6'd0;
      alm_sec        <= 6'd0;
      mode_reg       <= cacf_pkg::MODE_UNSET;
      start_seen     <= 1'b0;
      run_flag       <= 1'b0;
      armed_flag     <= 1'b0;
      ringing_flag   <= 1'b0;
      led_phase      <= 2'd0;
    end else if (advance) begin
      frame_head     <= head_next;
      frame_count    <= count_next;
      frame_chars_ok <= ok_next;
      clk_hour       <= hour_next;
      clk_min        <= min_next;
      clk_sec        <= sec_next;
      alm_hour       <= alm_hour_next;
      alm_min        <= alm_min_next;
      alm_sec        <= alm_sec_next;
      mode_reg       <= mode_next;
      start_seen     <= start_next;
      run_flag       <= run_next;
      armed_flag     <= armed_next;
      ringing_flag   <= ringing_next;
      led_phase      <= phase_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It loads the post-item state whenever an item moves on,
  // and drops its valid once its beat is taken with nothing behind it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.hour          <= hour_next;
      result.minute        <= min_next;
      result.second        <= sec_next;
      result.clock_mode    <= mode_next;
      result.clock_running <= run_next;
      result.alarm_armed   <= armed_next;
      result.alarm_ringing <= ringing_next;
      result.led_color     <= ringing_next ? cacf_pkg::phase_color(phase_next)
                                           : cacf_pkg::LED_OFF;
      result.frame_status  <= status_next;
      result.command_seen  <= cmd_next;
    end
  end

  assign result.valid = out_valid;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `CACF_ASSERT_IMPLY(a_led_tracks_ring, clk, rst, out_valid,
                     result.alarm_ringing == (result.led_color != cacf_pkg::LED_OFF))
  `CACF_ASSERT_IMPLY(a_cmd_needs_accept, clk, rst,
                     out_valid && (result.command_seen != cacf_pkg::CMD_NONE),
                     result.frame_status == cacf_pkg::FS_ACCEPT)
  `CACF_ASSERT_NEXT(a_run_sticky, clk, rst, run_flag, run_flag)
  `CACF_ASSERT_IMPLY(a_run_needs_mode, clk, rst, run_flag,
                     start_seen && (mode_reg != cacf_pkg::MODE_UNSET))
  `CACF_ASSERT_IMPLY(a_phase_range, clk, rst, 1'b1, led_phase != 2'd3)

endmodule

### sim/tb_clock_alarm_command_frames.sv
// Self-checking testbench for the command-frame clock with alarm.
`timescale 1ns / 1ps

module tb_clock_alarm_command_frames;
  import cacf_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_ITEMS  = 2000;
  // The long receiver hold-off; the block holds only a couple of beats, so the
  // sender is stalled for most of it.
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  // The block holds beats only in its input register and its result register, so
  // this margin settles everything after the last result.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  // Worst case is about 2500 beats, each with a long sender gap and a long
  // receiver stall, plus the hold-off. This is several times that.
  localparam int TIMEOUT_NS    = 10_000_000;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [1:0] mode;
    logic       running;
    logic       armed;
    logic       ringing;
    logic [1:0] led;
    logic [1:0] status;
    logic [2:0] cmd;
  } clock_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cacf_in_if  item_ch ();
  cacf_out_if result_ch ();

  clock_alarm_command_frames u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Knobs shared by the test tasks, the sender and the receiver process.
  bit src_idle     = 1'b0;
  bit sink_idle    = 1'b0;
  bit hold_off_req = 1'b0;

  int items_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;

  // Status beats predicted for accepted items, oldest first.
  clock_status_t status_due[$];

  // Frame being assembled by the stimulus tasks.
  logic [7:0] frame_buf[$];

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors what the block must remember: the first ten
  // characters of the frame in progress, how many characters arrived, whether
  // all of them were legal, the time of day, the alarm time and the flags.
  // ---------------------------------------------------------------------------
  logic [7:0] rx_head [HEAD_DEPTH];
  int         rx_count;
  logic       rx_clean;
  logic [4:0] tod_h, alm_h;
  logic [5:0] tod_m, tod_s, alm_m, alm_s;
  logic [1:0] cur_mode;
  logic       start_req, running, armed, ringing;
  // Index of the next color to step to; the color on show is the one before it.
  logic [1:0] color_phase;

  function automatic logic numeral(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic legal_char(input logic [7:0] c);
    return numeral(c) || (c >= CH_A && c <= CH_Z) || c == CH_LBR || c == CH_RBR;
  endfunction

  // AM style keeps hours 1 to 12, every other mode 0 to 23.
  function automatic logic hms_in_range(input logic [1:0] md, input int h, input int m,
                                        input int s);
    if (m > 59 || s > 59) return 1'b0;
    if (md == MODE_AM) return h >= 1 && h <= 12;
    return h <= 23;
  endfunction

  // One second forward. The hour wraps 12 to 1 in AM style and 23 to 0 otherwise;
  // out-of-range hours left from earlier settings wrap the same way.
  function automatic void tick_time(input logic [1:0] md, inout logic [4:0] h,
                                    inout logic [5:0] m, inout logic [5:0] s);
    if (s >= 59) begin
      s = '0;
      if (m >= 59) begin
        m = '0;
        if (md == MODE_AM) begin
          h = (h >= 12) ? 5'd1 : h + 5'd1;
        end else begin
          h = (h >= 23) ? 5'd0 : h + 5'd1;
        end
      end else begin
        m = m + 6'd1;
      end
    end else begin
      s = s + 6'd1;
    end
  endfunction

  function automatic logic [1:0] next_phase(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  function automatic void clear_frame_state();
    foreach (rx_head[i]) rx_head[i] = '0;
    rx_count = 0;
    rx_clean = 1'b1;
  endfunction

  function automatic void reset_predictor();
    clear_frame_state();
    {tod_h, tod_m, tod_s} = '0;
    {alm_h, alm_m, alm_s} = '0;
    cur_mode    = MODE_UNSET;
    start_req   = 1'b0;
    running     = 1'b0;
    armed       = 1'b0;
    ringing     = 1'b0;
    color_phase = 2'd0;
  endfunction

  // The alarm fires on an exact match of all three fields, never while it rings.
  function automatic void alarm_compare();
    if (armed && !ringing && {tod_h, tod_m, tod_s} == {alm_h, alm_m, alm_s}) begin
      ringing     = 1'b1;
      color_phase = next_phase(color_phase);
    end
  endfunction

  // Acts on an accepted frame and returns the command code it reports.
  function automatic logic [2:0] run_command();
    logic       all_num;
    int         hh, mm, ss;
    logic [2:0] cmd;
    all_num = 1'b1;
    cmd     = CMD_NONE;
    for (int i = 3; i <= 8; i++) begin
      if (!numeral(rx_head[i])) all_num = 1'b0;
    end
    hh = 10 * (rx_head[3] - CH_0) + (rx_head[4] - CH_0);
    mm = 10 * (rx_head[5] - CH_0) + (rx_head[6] - CH_0);
    ss = 10 * (rx_head[7] - CH_0) + (rx_head[8] - CH_0);
    if (rx_head[1] == CH_S && rx_head[2] == CH_T) begin
      start_req = 1'b1;
      cmd       = CMD_START;
    end else if (all_num) begin
      if (rx_head[1] == CH_H && rx_head[2] == CH_G) begin
        // An alarm needs a mode and a time that is legal in that mode.
        if ((cur_mode == MODE_AM || cur_mode == MODE_PM) &&
            hms_in_range(cur_mode, hh, mm, ss)) begin
          armed = 1'b1;
          alm_h = 5'(hh);
          alm_m = 6'(mm);
          alm_s = 6'(ss);
          cmd   = CMD_ALARM;
        end
      end else if ((rx_head[1] == CH_A || rx_head[1] == CH_P) && rx_head[2] == CH_M) begin
        // The mode changes even when the time is out of range; the time is then kept.
        cur_mode = (rx_head[1] == CH_A) ? MODE_AM : MODE_PM;
        if (hms_in_range(cur_mode, hh, mm, ss)) begin
          tod_h = 5'(hh);
          tod_m = 6'(mm);
          tod_s = 6'(ss);
        end
        cmd = (rx_head[1] == CH_A) ? CMD_AM : CMD_PM;
      end
    end
    if (start_req && (cur_mode == MODE_AM || cur_mode == MODE_PM)) running = 1'b1;
    return cmd;
  endfunction

  // Applies one accepted item to the predictor and returns the status beat it causes.
  function automatic clock_status_t apply_item(input logic [1:0] act, input logic [7:0] ch,
                                               input logic last);
    clock_status_t r;
    logic [1:0]    st;
    logic [2:0]    cmd;
    st  = FS_NONE;
    cmd = CMD_NONE;
    case (act)
      ACT_BYTE: begin
        // Past the buffer limit the count saturates and the frame is spoiled.
        if (rx_count >= MAX_FRAME_DEF) begin
          rx_clean = 1'b0;
        end else begin
          if (rx_count < HEAD_DEPTH) rx_head[rx_count] = ch;
          rx_count++;
          if (!legal_char(ch)) rx_clean = 1'b0;
        end
        if (last) begin
          if (rx_clean && rx_head[0] == CH_LBR &&
              (rx_head[6] == CH_RBR || rx_head[9] == CH_RBR)) begin
            st  = FS_ACCEPT;
            cmd = run_command();
            alarm_compare();
          end else begin
            st = FS_REJECT;
          end
          clear_frame_state();
        end
      end
      ACT_TICK: begin
        // A ringing alarm steps its color on every tick, running or not.
        if (ringing) color_phase = next_phase(color_phase);
        if (running) begin
          tick_time(cur_mode, tod_h, tod_m, tod_s);
          alarm_compare();
        end
      end
      ACT_STOP: begin
        ringing = 1'b0;
      end
      default: begin
      end
    endcase
    r.hour    = tod_h;
    r.minute  = tod_m;
    r.second  = tod_s;
    r.mode    = cur_mode;
    r.running = running;
    r.armed   = armed;
    r.ringing = ringing;
    r.status  = st;
    r.cmd     = cmd;
    if (!ringing) begin
      r.led = LED_OFF;
    end else begin
      case (color_phase)
        2'd0:    r.led = LED_RED;
        2'd1:    r.led = LED_BLUE;
        default: r.led = LED_GREEN;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item side. Every accepted beat is run through the predictor at the edge
  // that accepts it, so prediction follows the block's own order exactly.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) begin
      status_due.push_back(apply_item(item_ch.action, item_ch.rx_byte, item_ch.frame_end));
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offers one beat and returns after the edge that takes it. The next call
  // either keeps valid high with a new payload or drops it for a gap, so valid
  // sees a single assignment per edge.
  task automatic send_item(input logic [1:0] act, input logic [7:0] ch, input logic last);
    int gap;
    gap = src_idle ? idle_len() : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.action    <= act;
    item_ch.rx_byte   <= ch;
    item_ch.frame_end <= last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Ticks and stops carry random bytes and end marks, which the block must ignore.
  task automatic send_tick();
    send_item(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_stop();
    send_item(ACT_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(ACT_BYTE, s[i], i == s.len() - 1);
    end
  endtask

  // Sends frame_buf, now and then slipping a tick in between two characters.
  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      if ($urandom_range(0, 99) < 3) send_tick();
      send_item(ACT_BYTE, frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  function automatic logic [7:0] legal_pick();
    case ($urandom_range(0, 2))
      0:       return CH_0 + 8'($urandom_range(0, 9));
      1:       return CH_A + 8'($urandom_range(0, 25));
      default: return $urandom_range(0, 1) ? CH_LBR : CH_RBR;
    endcase
  endfunction

  function automatic void put_pair(input int v);
    frame_buf.push_back(CH_0 + 8'(v / 10));
    frame_buf.push_back(CH_0 + 8'(v % 10));
  endfunction

  // Times biased toward the rollovers and the range limits, with some nonsense.
  task automatic pick_time(output int hh, output int mm, output int ss);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0:       hh = 11;
          1:       hh = 12;
          2:       hh = 23;
          3:       hh = 0;
          default: hh = $urandom_range(1, 12);
        endcase
        mm = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
        ss = $urandom_range(50, 59);
      end
      1: begin
        hh = $urandom_range(0, 23);
        mm = $urandom_range(0, 59);
        ss = $urandom_range(0, 59);
      end
      2: begin
        hh = $urandom_range(0, 99);
        mm = $urandom_range(0, 99);
        ss = $urandom_range(0, 99);
      end
      default: begin
        case ($urandom_range(0, 5))
          0:       hh = 0;
          1:       hh = 1;
          2:       hh = 12;
          3:       hh = 13;
          4:       hh = 23;
          default: hh = 24;
        endcase
        case ($urandom_range(0, 2))
          0:       mm = 0;
          1:       mm = 59;
          default: mm = 60;
        endcase
        case ($urandom_range(0, 2))
          0:       ss = 0;
          1:       ss = 59;
          default: ss = 60;
        endcase
      end
    endcase
  endtask

  // A well-formed command frame with random content. Alarm frames mostly aim a
  // few seconds ahead of the predicted clock, or right at it, so that the alarm
  // really fires, also on the frame itself.
  task automatic send_command_frame();
    int         kind, hh, mm, ss, k, pos;
    logic [4:0] th;
    logic [5:0] tm, ts;
    frame_buf.delete();
    frame_buf.push_back(CH_LBR);
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      frame_buf.push_back(CH_S);
      frame_buf.push_back(CH_T);
      repeat (3) frame_buf.push_back(legal_pick());
      if ($urandom_range(0, 1)) begin
        repeat (3) frame_buf.push_back(legal_pick());
      end
      frame_buf.push_back(CH_RBR);
    end else begin
      if (kind < 4) begin
        frame_buf.push_back(CH_A);
        frame_buf.push_back(CH_M);
      end else if (kind < 6) begin
        frame_buf.push_back(CH_P);
        frame_buf.push_back(CH_M);
      end else if (kind < 9) begin
        frame_buf.push_back(CH_H);
        frame_buf.push_back(CH_G);
      end else begin
        frame_buf.push_back(CH_A + 8'($urandom_range(0, 25)));
        frame_buf.push_back(CH_A + 8'($urandom_range(0, 25)));
      end
      if (kind >= 6 && kind < 9 && $urandom_range(0, 9) < 6) begin
        th = tod_h;
        tm = tod_m;
        ts = tod_s;
        k  = $urandom_range(0, 4);
        repeat (k) tick_time(cur_mode, th, tm, ts);
        hh = int'(th);
        mm = int'(tm);
        ss = int'(ts);
      end else begin
        pick_time(hh, mm, ss);
      end
      put_pair(hh);
      put_pair(mm);
      put_pair(ss);
      // A letter among the time digits leaves an accepted frame without effect.
      if ($urandom_range(0, 9) == 0) begin
        pos = $urandom_range(3, 8);
        frame_buf[pos] = CH_A + 8'($urandom_range(0, 25));
      end
      frame_buf.push_back(CH_RBR);
    end
    send_frame();
  endtask

  // Short frames of mixed legal and arbitrary bytes; some pass by chance.
  task automatic send_broken_frame();
    int len, pos;
    frame_buf.delete();
    len = $urandom_range(1, 12);
    repeat (len) begin
      frame_buf.push_back(($urandom_range(0, 9) < 6) ? legal_pick() :
                          8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 7) frame_buf[0] = CH_LBR;
    if ($urandom_range(0, 1)) begin
      pos = $urandom_range(0, 1) ? 6 : 9;
      if (pos < len) frame_buf[pos] = CH_RBR;
    end
    send_frame();
  endtask

  // Lengths around the buffer limit: the frame passes up to the limit and is
  // rejected beyond it.
  task automatic send_long_frame();
    int len;
    frame_buf.delete();
    len = $urandom_range(MAX_FRAME_DEF - 2, MAX_FRAME_DEF + 4);
    repeat (len) frame_buf.push_back(legal_pick());
    frame_buf[0] = CH_LBR;
    frame_buf[9] = CH_RBR;
    send_frame();
  endtask

  task automatic send_noise_byte();
    send_item(ACT_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver takes beats at random, with stalls of random
  // length, and once holds off for a long stretch on request.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 99) < 30) begin
        n = idle_len();
        if (n == 0) n = 1;
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("result beat %0d: %s expected %0d, got %0d", results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    clock_status_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("result beat %0d arrived with nothing outstanding", results_seen);
        end
      end else begin
        want = status_due.pop_front();
        check_field("hour", want.hour, result_ch.hour);
        check_field("minute", want.minute, result_ch.minute);
        check_field("second", want.second, result_ch.second);
        check_field("clock_mode", want.mode, result_ch.clock_mode);
        check_field("clock_running", want.running, result_ch.clock_running);
        check_field("alarm_armed", want.armed, result_ch.alarm_armed);
        check_field("alarm_ringing", want.ringing, result_ch.alarm_ringing);
        check_field("led_color", want.led, result_ch.led_color);
        check_field("frame_status", want.status, result_ch.frame_status);
        check_field("command_seen", want.cmd, result_ch.command_seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Ticks and a stop before anything is set must change nothing. Then the clock
  // is set just before midnight in 24-hour style, started, and ticked across the
  // hour wrap. The two extreme byte values close the test as a rejected frame.
  task automatic test_clock_basics();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_tick();
    send_stop();
    send_text("[PM235958]");
    send_text("[ST000]");
    send_tick();
    send_tick();
    send_stop();
    send_item(ACT_BYTE, 8'h00, 1'b0);
    send_item(ACT_BYTE, 8'hFF, 1'b1);
  endtask

  // Twelve-hour style wraps 12 to 1. The alarm is armed two seconds ahead,
  // fires, steps through its colors, is stopped, and is then armed at the
  // current time so that it fires a second time on the frame itself.
  task automatic test_alarm_cycle();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_text("[AM125958]");
    send_tick();
    send_tick();
    send_text("[HG010002]");
    repeat (4) send_tick();
    send_stop();
    send_text("[HG010004]");
    send_tick();
    send_stop();
  endtask

  // The receiver holds off while the sender keeps offering beats with no gaps,
  // so the block fills up and must stall its input without losing anything.
  task automatic test_backpressure();
    src_idle     = 1'b0;
    sink_idle    = 1'b0;
    hold_off_req = 1'b1;
    send_text("[PM115958]");
    repeat (30) send_tick();
  endtask

  // Mostly well-formed command frames and tick bursts, with stops, broken
  // frames, stray bytes and a few frames around the buffer limit. Idling on
  // each side is switched per stretch, including stretches with none at all.
  task automatic test_random_traffic();
    int stop_at, seg_end, r;
    stop_at = items_sent + RANDOM_ITEMS;
    seg_end = items_sent;
    while (items_sent < stop_at) begin
      if (items_sent >= seg_end) begin
        r         = $urandom_range(0, 3);
        src_idle  = r[0];
        sink_idle = r[1];
        seg_end   = items_sent + $urandom_range(100, 300);
      end
      r = $urandom_range(0, 299);
      if (r < 2) begin
        send_long_frame();
      end else if (r < 105) begin
        send_command_frame();
      end else if (r < 210) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else if (r < 235) begin
        send_stop();
      end else if (r < 270) begin
        send_broken_frame();
      end else begin
        send_noise_byte();
      end
    end
  endtask

  // Stops offering, waits for every outstanding beat, then lets the block settle.
  task automatic drain_results();
    int waited;
    waited = 0;
    item_ch.valid <= 1'b0;
    while (status_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (status_due.size() != 0) begin
      mismatches += status_due.size();
      $display("%0d expected result beats never arrived", status_due.size());
    end
  endtask

  initial begin
    item_ch.valid     <= 1'b0;
    item_ch.action    <= ACT_TICK;
    item_ch.rx_byte   <= '0;
    item_ch.frame_end <= 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_clock_basics();
    test_alarm_cycle();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (mismatches == 0) begin
      $display("** clock_alarm_command_frames: PASSED **");
    end else begin
      $display("** clock_alarm_command_frames: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result beats outstanding", status_due.size());
    $display("** clock_alarm_command_frames: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cacf_pkg.sv
rtl/core/cacf_if.sv
rtl/core/clock_alarm_command_frames.sv
sim/tb_clock_alarm_command_frames.sv
